### rtl/ascd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascd_pkg
// Shared types and constants for the converter smoothing / change detector.
// ----------------------------------------------------------------------------
package ascd_pkg;

  localparam int unsigned SMPL_W     = 12;
  localparam int unsigned DELTA_W    = 14;
  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned REG_DATA_W = 32;

  localparam logic [SMPL_W-1:0] SMPL_MAX = 12'd4095;
  localparam logic [16:0]       COEF_ONE = 17'h10000;

  // Voltage channels below this index use the "time" coefficient and deadband.
  localparam logic [2:0] CV_TIME_CHANNELS = 3'd2;

  typedef enum logic [2:0] {
    REG_KNOB_COEF       = 3'd0,
    REG_CV_TIME_COEF    = 3'd1,
    REG_CV_OTHER_COEF   = 3'd2,
    REG_KNOB_MIN_CHANGE = 3'd3,
    REG_CV_TIME_MIN     = 3'd4,
    REG_CV_OTHER_MIN    = 3'd5,
    REG_HOLD_TICKS      = 3'd6,
    REG_CALIBRATE_MODE  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] knob_coef;
    logic [15:0] cv_time_coef;
    logic [15:0] cv_other_coef;
    logic [11:0] knob_min_change;
    logic [11:0] cv_time_min_change;
    logic [11:0] cv_other_min_change;
    logic [7:0]  hold_ticks;
    logic        calibrate_mode;
  } cfg_t;

  typedef struct packed {
    logic        source;
    logic [2:0]  channel;
    logic [11:0] sample;
    logic [11:0] cal_offset;
  } item_t;

  // Per-channel state words as kept in the state memories.
  typedef struct packed {
    logic [27:0] filter;
    logic [11:0] settled;
    logic [7:0]  hold;
  } knob_state_t;

  typedef struct packed {
    logic [31:0] filter;
    logic [27:0] raw;
    logic [11:0] settled;
  } cv_state_t;

  typedef struct packed {
    logic        source;
    logic [2:0]  channel;
    logic [11:0] smoothed;
    logic [11:0] raw_smoothed;
    logic        moving;
    logic        delta_valid;
    logic [13:0] delta;
    logic [11:0] settled;
  } result_t;

endpackage

### rtl/ascd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascd_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ascd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/ascd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascd_regs
// APB register file holding the filter coefficients, deadbands and mode.
// ----------------------------------------------------------------------------
module ascd_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ascd_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [ascd_pkg::REG_DATA_W-1:0]     pwdata,
  output logic [ascd_pkg::REG_DATA_W-1:0]     prdata,
  output ascd_pkg::cfg_t                      cfg
);

  import ascd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[4:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_KNOB_COEF:       cfg_nxt.knob_coef           = pwdata[15:0];
        REG_CV_TIME_COEF:    cfg_nxt.cv_time_coef        = pwdata[15:0];
        REG_CV_OTHER_COEF:   cfg_nxt.cv_other_coef       = pwdata[15:0];
        REG_KNOB_MIN_CHANGE: cfg_nxt.knob_min_change     = pwdata[11:0];
        REG_CV_TIME_MIN:     cfg_nxt.cv_time_min_change  = pwdata[11:0];
        REG_CV_OTHER_MIN:    cfg_nxt.cv_other_min_change = pwdata[11:0];
        REG_HOLD_TICKS:      cfg_nxt.hold_ticks          = pwdata[7:0];
        REG_CALIBRATE_MODE:  cfg_nxt.calibrate_mode      = pwdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.knob_coef           <= 16'd62259;
      cfg_r.cv_time_coef        <= 16'd64225;
      cfg_r.cv_other_coef       <= 16'd58982;
      cfg_r.knob_min_change     <= 12'd60;
      cfg_r.cv_time_min_change  <= 12'd30;
      cfg_r.cv_other_min_change <= 12'd20;
      cfg_r.hold_ticks          <= 8'd250;
      cfg_r.calibrate_mode      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_KNOB_COEF:       prdata = {16'b0, cfg_r.knob_coef};
      REG_CV_TIME_COEF:    prdata = {16'b0, cfg_r.cv_time_coef};
      REG_CV_OTHER_COEF:   prdata = {16'b0, cfg_r.cv_other_coef};
      REG_KNOB_MIN_CHANGE: prdata = {20'b0, cfg_r.knob_min_change};
      REG_CV_TIME_MIN:     prdata = {20'b0, cfg_r.cv_time_min_change};
      REG_CV_OTHER_MIN:    prdata = {20'b0, cfg_r.cv_other_min_change};
      REG_HOLD_TICKS:      prdata = {24'b0, cfg_r.hold_ticks};
      REG_CALIBRATE_MODE:  prdata = {31'b0, cfg_r.calibrate_mode};
      default:             prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### rtl/ascd_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascd_update
// One channel update: low-pass step, clamp, deadband / hold-counter logic.
// ----------------------------------------------------------------------------
module ascd_update (
  input  ascd_pkg::item_t       item,
  input  ascd_pkg::cfg_t        cfg,
  input  logic                  knob_sel,
  input  logic                  cv_sel,
  input  ascd_pkg::knob_state_t knob_cur,
  input  ascd_pkg::cv_state_t   cv_cur,
  output ascd_pkg::knob_state_t knob_new,
  output ascd_pkg::cv_state_t   cv_new,
  output ascd_pkg::result_t     res
);

  import ascd_pkg::*;

  // knob path: state is non-negative, bounded by 4095 * 2^16
  logic [43:0]        kp;
  logic [16:0]        km;
  logic [28:0]        kq;
  logic [27:0]        kf_nxt;
  logic [11:0]        k_sm;
  logic signed [13:0] k_t;
  logic signed [13:0] k_md;
  logic               k_move;
  logic [7:0]         k_hold_ld;
  logic               k_act;

  assign km     = COEF_ONE - {1'b0, cfg.knob_coef};
  assign kp     = {16'b0, knob_cur.filter} * {28'b0, cfg.knob_coef};
  assign kq     = {17'b0, item.sample} * {12'b0, km};
  assign kf_nxt = kp[43:16] + kq[27:0];
  assign k_sm   = kf_nxt[27:16];
  assign k_t    = $signed({2'b0, k_sm}) - $signed({2'b0, knob_cur.settled});
  assign k_md   = $signed({2'b0, cfg.knob_min_change});
  assign k_move = (k_t > k_md) || (k_t < -k_md);
  assign k_hold_ld = k_move ? cfg.hold_ticks : knob_cur.hold;
  assign k_act  = (k_hold_ld != 8'd0);

  // voltage path: offset sample can go negative, state kept signed
  logic [15:0]        c_coef;
  logic [11:0]        c_min;
  logic [16:0]        cm;
  logic signed [13:0] cx;
  logic signed [48:0] cp;
  logic signed [31:0] cq;
  logic signed [31:0] cf_nxt;
  logic [11:0]        c_sm;
  logic [43:0]        rp;
  logic [28:0]        rq;
  logic [27:0]        rf_nxt;
  logic [27:0]        rf_new;
  logic signed [13:0] c_t;
  logic signed [13:0] c_md;
  logic               c_move;

  assign c_coef = (item.channel < CV_TIME_CHANNELS) ? cfg.cv_time_coef : cfg.cv_other_coef;
  assign c_min  = (item.channel < CV_TIME_CHANNELS) ? cfg.cv_time_min_change
                                                    : cfg.cv_other_min_change;
  assign cm     = COEF_ONE - {1'b0, c_coef};
  assign cx     = $signed({2'b0, item.sample})
                + $signed({{2{item.cal_offset[11]}}, item.cal_offset});
  assign cp     = $signed({{17{cv_cur.filter[31]}}, cv_cur.filter}) * $signed({33'b0, c_coef});
  assign cq     = $signed({{18{cx[13]}}, cx}) * $signed({15'b0, cm});
  assign cf_nxt = $signed(cp[47:16]) + cq;

  // clamp integer part to the converter range
  always_comb begin
    if (cf_nxt[31]) begin
      c_sm = '0;
    end else if (|cf_nxt[30:28]) begin
      c_sm = SMPL_MAX;
    end else begin
      c_sm = cf_nxt[27:16];
    end
  end

  assign rp     = {16'b0, cv_cur.raw} * {28'b0, c_coef};
  assign rq     = {17'b0, item.sample} * {12'b0, cm};
  assign rf_nxt = rp[43:16] + rq[27:0];
  assign rf_new = cfg.calibrate_mode ? rf_nxt : cv_cur.raw;
  assign c_t    = $signed({2'b0, c_sm}) - $signed({2'b0, cv_cur.settled});
  assign c_md   = $signed({2'b0, c_min});
  assign c_move = (c_t > c_md) || (c_t < -c_md);

  always_comb begin
    knob_new    = knob_cur;
    cv_new      = cv_cur;
    res         = '0;
    res.source  = item.source;
    res.channel = item.channel;
    if (knob_sel) begin
      knob_new.filter = kf_nxt;
      knob_new.hold   = k_act ? (k_hold_ld - 8'd1) : k_hold_ld;
      res.smoothed    = k_sm;
      if (k_act) begin
        knob_new.settled = k_sm;
        res.moving       = 1'b1;
        res.delta_valid  = 1'b1;
        res.delta        = k_t;
      end
      res.settled = knob_new.settled;
    end else if (cv_sel) begin
      cv_new.filter    = cf_nxt;
      cv_new.raw       = rf_new;
      res.smoothed     = c_sm;
      res.raw_smoothed = rf_new[27:16];
      if (c_move) begin
        cv_new.settled  = c_sm;
        res.delta_valid = 1'b1;
        res.delta       = c_t;
      end
      res.settled = cv_new.settled;
    end
  end

endmodule

### rtl/adc_smoothing_change_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_smoothing_change_detector
// Per-channel one-pole smoothing with deadband / hold change detection.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one sample per transaction. in_tuser = source (0 knob, 1 CV);
//            in_tdata = channel, sample, cal_offset (low bits up).
//   out_*  : one result per input transaction, same order. out_tuser = source
//            echo; out_tdata carries channel and the smoothed / delta fields.
//   cfg_*  : APB register port, registers at byte offset 4*index, pready
//            tied high. Write only while the block is idle.
// Path  : input acceptance, compute stage registers, result register, out_tvalid.
// Throughput: one transaction per cycle while results are taken, same channel back to back included.
//   Item is accepted and its channel's state read from the state RAM together;
//   the compute stage then runs the filter step and writes the state back as it advances.
//   A write to the entry being read in that same cycle is forwarded.
// Reset : synchronous; all filter, settled and hold state reads as zero
//   through per-entry valid bits, registers return to defaults. No sweep.
// Stall : with out_tready low the result register holds, the compute stage
//   holds one more item, and in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module adc_smoothing_change_detector #(
  parameter int unsigned KNOB_CHANNELS = 8,
  parameter int unsigned CV_CHANNELS   = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,  // channel[2:0] sample[14:3] cal_offset[26:15]
  input  logic                             in_tuser,  // source
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // channel[2:0] smoothed[14:3] raw_smoothed[26:15] moving[27] delta_valid[28]
  // delta[42:29] settled[54:43]
  output logic [55:0]                      out_tdata,
  output logic                             out_tuser, // out_source
  // configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ascd_pkg::REG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ascd_pkg::REG_DATA_W-1:0]  cfg_pwdata,
  output logic [ascd_pkg::REG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  import ascd_pkg::*;

  localparam int unsigned KAW = (KNOB_CHANNELS > 1) ? $clog2(KNOB_CHANNELS) : 1;
  localparam int unsigned CAW = (CV_CHANNELS > 1) ? $clog2(CV_CHANNELS) : 1;
  localparam int unsigned KSW = $bits(knob_state_t);
  localparam int unsigned CSW = $bits(cv_state_t);

  cfg_t cfg;

  ascd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // ---------------------------------------------------------------- intake
  item_t          in_item;
  logic           accept;
  logic           in_knob;
  logic           in_cv;
  logic [KAW-1:0] in_kaddr;
  logic [CAW-1:0] in_caddr;

  assign in_item.source     = in_tuser;
  assign in_item.channel    = in_tdata[2:0];
  assign in_item.sample     = in_tdata[14:3];
  assign in_item.cal_offset = in_tdata[26:15];

  assign accept   = in_tvalid && in_tready;
  assign in_knob  = !in_item.source && (32'(in_item.channel) < KNOB_CHANNELS);
  assign in_cv    = in_item.source && (32'(in_item.channel) < CV_CHANNELS);
  // out-of-range channels read entry zero; their state is never touched
  assign in_kaddr = in_knob ? KAW'(in_item.channel) : '0;
  assign in_caddr = in_cv ? CAW'(in_item.channel) : '0;

  // ---------------------------------------------------- compute stage regs
  logic           s1_valid_r;
  logic           s1_valid_nxt;
  item_t          s1_item_r;
  logic           s1_knob_r;
  logic           s1_cv_r;
  logic [KAW-1:0] s1_kaddr_r;
  logic [CAW-1:0] s1_caddr_r;
  logic           s1_kvld_r;
  logic           s1_cvld_r;
  logic           s1_kfwd_r;
  logic           s1_cfwd_r;
  knob_state_t    s1_kfwd_data_r;
  cv_state_t      s1_cfwd_data_r;

  logic           out_free;
  logic           s1_adv;
  logic           k_wr;
  logic           c_wr;

  knob_state_t    k_rd;
  cv_state_t      c_rd;
  knob_state_t    k_cur;
  cv_state_t      c_cur;
  knob_state_t    k_new;
  cv_state_t      c_new;
  result_t        res;

  logic [KNOB_CHANNELS-1:0] knob_vld_r;
  logic [CV_CHANNELS-1:0]   cv_vld_r;

  assign out_free  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign k_wr      = s1_adv && s1_knob_r;
  assign c_wr      = s1_adv && s1_cv_r;

  // -------------------------------------------------------- state memories
  ascd_ram #(.WIDTH(KSW), .DEPTH(KNOB_CHANNELS), .AW(KAW)) u_knob_ram (
    .clk   (clk),
    .we    (k_wr),
    .waddr (s1_kaddr_r),
    .wdata (k_new),
    .re    (accept),
    .raddr (in_kaddr),
    .rdata (k_rd)
  );

  ascd_ram #(.WIDTH(CSW), .DEPTH(CV_CHANNELS), .AW(CAW)) u_cv_ram (
    .clk   (clk),
    .we    (c_wr),
    .waddr (s1_caddr_r),
    .wdata (c_new),
    .re    (accept),
    .raddr (in_caddr),
    .rdata (c_rd)
  );

  // Read-modify-write hazard: the only write the read can miss is the one
  // landing on the same edge as the read, so capture it alongside the item.
  // Entries never written since reset read as zero.
  always_comb begin
    if (s1_kfwd_r) begin
      k_cur = s1_kfwd_data_r;
    end else if (s1_kvld_r) begin
      k_cur = k_rd;
    end else begin
      k_cur = '0;
    end
    if (s1_cfwd_r) begin
      c_cur = s1_cfwd_data_r;
    end else if (s1_cvld_r) begin
      c_cur = c_rd;
    end else begin
      c_cur = '0;
    end
  end

  ascd_update u_update (
    .item     (s1_item_r),
    .cfg      (cfg),
    .knob_sel (s1_knob_r),
    .cv_sel   (s1_cv_r),
    .knob_cur (k_cur),
    .cv_cur   (c_cur),
    .knob_new (k_new),
    .cv_new   (c_new),
    .res      (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      knob_vld_r <= '0;
      cv_vld_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (k_wr) begin
        knob_vld_r[s1_kaddr_r] <= 1'b1;
      end
      if (c_wr) begin
        cv_vld_r[s1_caddr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r      <= in_item;
      s1_knob_r      <= in_knob;
      s1_cv_r        <= in_cv;
      s1_kaddr_r     <= in_kaddr;
      s1_caddr_r     <= in_caddr;
      s1_kvld_r      <= knob_vld_r[in_kaddr];
      s1_cvld_r      <= cv_vld_r[in_caddr];
      s1_kfwd_r      <= k_wr && (s1_kaddr_r == in_kaddr);
      s1_cfwd_r      <= c_wr && (s1_caddr_r == in_caddr);
      s1_kfwd_data_r <= k_new;
      s1_cfwd_data_r <= c_new;
    end
  end

  // --------------------------------------------------------- result register
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;

  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.source;
  assign out_tdata  = {1'b0, out_res_r.settled, out_res_r.delta, out_res_r.delta_valid,
                       out_res_r.moving, out_res_r.raw_smoothed, out_res_r.smoothed,
                       out_res_r.channel};

endmodule

### sim/adc_smoothing_change_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_smoothing_change_detector_test
// Self-checking bench for the converter smoothing / change detector. A queue-fed
// stream driver pushes knob and voltage samples, a scoreboard predicts every
// result from its own copy of the filter, settled and hold state, and a monitor
// compares each result transaction field by field. Registers are rewritten over
// APB between phases while the block is drained.
// ----------------------------------------------------------------------------
module adc_smoothing_change_detector_test;
  import ascd_pkg::*;

  localparam int KNOB_CH     = 8;
  localparam int CV_CH       = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 275;

  // one pending stimulus transaction; drain holds it back until the
  // scoreboard is empty
  typedef struct {
    item_t it;
    bit    drain;
  } pend_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [REG_ADDR_W-1:0] cfg_paddr = '0;
  logic [REG_DATA_W-1:0] cfg_pwdata = '0;
  logic [REG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  adc_smoothing_change_detector #(
    .KNOB_CHANNELS(KNOB_CH),
    .CV_CHANNELS  (CV_CH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard state: register shadow plus per-channel filter state.
  // Accumulators carry 16 fraction bits; longint keeps the signed voltage
  // filter and the products exact.
  // ---------------------------------------------------------------------------
  cfg_t        shadow_cfg;
  longint      knob_acc   [KNOB_CH];
  logic [11:0] knob_set   [KNOB_CH];
  logic [7:0]  knob_cnt   [KNOB_CH];
  longint      cv_acc     [CV_CH];
  longint      cv_raw_acc [CV_CH];
  logic [11:0] cv_set     [CV_CH];

  pend_t   stim_q[$];
  result_t exp_results[$];
  item_t   cur_item;

  int error_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int cycle_cnt = 0;

  // per-channel last sample, so random stimulus mostly walks like a real knob
  logic [11:0] walk_knob[8];
  logic [11:0] walk_cv[8];

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // One pole step: floor((acc*c + x*2^16*(2^16-c)) / 2^16). Arithmetic shift
  // gives the floor for negative numerators too.
  function automatic longint lp_step(longint acc, longint x, logic [15:0] c);
    longint num;
    num = acc * longint'(c) + x * (longint'(65536) - longint'(c)) * 65536;
    return num >>> 16;
  endfunction

  // integer part, clamped to the 12-bit range
  function automatic logic [11:0] clamp12(longint acc);
    if (acc < 0) return 12'd0;
    if ((acc >>> 16) > 4095) return SMPL_MAX;
    return 12'(acc >>> 16);
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t     r;
    longint      t;
    longint      md;
    logic [15:0] c;
    int          ch;
    r = '0;
    r.source  = it.source;
    r.channel = it.channel;
    ch = int'(it.channel);
    if (!it.source) begin
      // 3-bit channel always addresses one of the eight knobs
      knob_acc[ch] = lp_step(knob_acc[ch], longint'(it.sample), shadow_cfg.knob_coef);
      r.smoothed = clamp12(knob_acc[ch]);
      t  = longint'(r.smoothed) - longint'(knob_set[ch]);
      md = longint'(shadow_cfg.knob_min_change);
      if (t > md || t < -md) knob_cnt[ch] = shadow_cfg.hold_ticks;
      if (knob_cnt[ch] != 8'd0) begin
        knob_cnt[ch]  = knob_cnt[ch] - 8'd1;
        r.moving      = 1'b1;
        r.delta_valid = 1'b1;
        r.delta       = 14'(t);
        knob_set[ch]  = r.smoothed;
      end
      r.settled = knob_set[ch];
    end else if (ch < CV_CH) begin
      c  = (ch < int'(CV_TIME_CHANNELS)) ? shadow_cfg.cv_time_coef : shadow_cfg.cv_other_coef;
      md = longint'((ch < int'(CV_TIME_CHANNELS)) ? shadow_cfg.cv_time_min_change
                                                  : shadow_cfg.cv_other_min_change);
      cv_acc[ch] = lp_step(cv_acc[ch],
                           longint'(it.sample) + longint'($signed(it.cal_offset)), c);
      r.smoothed = clamp12(cv_acc[ch]);
      if (shadow_cfg.calibrate_mode)
        cv_raw_acc[ch] = lp_step(cv_raw_acc[ch], longint'(it.sample), c);
      r.raw_smoothed = clamp12(cv_raw_acc[ch]);
      t = longint'(r.smoothed) - longint'(cv_set[ch]);
      if (t > md || t < -md) begin
        r.delta_valid = 1'b1;
        r.delta       = 14'(t);
        cv_set[ch]    = r.smoothed;
      end
      r.settled = cv_set[ch];
    end
    // voltage channel past the channel count: echoes only, state untouched
    return r;
  endfunction

  task automatic check_result(result_t got, result_t want);
    if (got.source !== want.source)
      report_mismatch("source", got.source, want.source);
    if (got.channel !== want.channel)
      report_mismatch("channel", got.channel, want.channel);
    if (got.smoothed !== want.smoothed)
      report_mismatch("smoothed", got.smoothed, want.smoothed);
    if (got.raw_smoothed !== want.raw_smoothed)
      report_mismatch("raw_smoothed", got.raw_smoothed, want.raw_smoothed);
    if (got.moving !== want.moving)
      report_mismatch("moving", got.moving, want.moving);
    if (got.delta_valid !== want.delta_valid)
      report_mismatch("delta_valid", got.delta_valid, want.delta_valid);
    if (got.delta !== want.delta)
      report_mismatch("delta", longint'($signed(got.delta)), longint'($signed(want.delta)));
    if (got.settled !== want.settled)
      report_mismatch("settled", got.settled, want.settled);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: presents the head of stim_q, holds it until accepted, and
  // books the prediction on the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drv
    pend_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        exp_results.push_back(predict_result(cur_item));
      if (!in_tvalid || in_tready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= snd_idle_pct &&
            (!stim_q[0].drain || exp_results.size() == 0)) begin
          nxt = stim_q.pop_front();
          cur_item  <= nxt.it;
          in_tdata  <= {5'd0, nxt.it.cal_offset, nxt.it.sample, nxt.it.channel};
          in_tuser  <= nxt.it.source;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random backpressure, compares each result transaction
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.source       = out_tuser;
        got.channel      = out_tdata[2:0];
        got.smoothed     = out_tdata[14:3];
        got.raw_smoothed = out_tdata[26:15];
        got.moving       = out_tdata[27];
        got.delta_valid  = out_tdata[28];
        got.delta        = out_tdata[42:29];
        got.settled      = out_tdata[54:43];
        if (exp_results.size() == 0) begin
          report_mismatch("unexpected result, channel", got.channel, -1);
        end else begin
          want = exp_results.pop_front();
          check_result(got, want);
        end
      end
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access. The register takes pwdata at the access edge; the shadow
  // follows at the same point.
  // ---------------------------------------------------------------------------
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_KNOB_COEF:       shadow_cfg.knob_coef           = val[15:0];
      REG_CV_TIME_COEF:    shadow_cfg.cv_time_coef        = val[15:0];
      REG_CV_OTHER_COEF:   shadow_cfg.cv_other_coef       = val[15:0];
      REG_KNOB_MIN_CHANGE: shadow_cfg.knob_min_change     = val[11:0];
      REG_CV_TIME_MIN:     shadow_cfg.cv_time_min_change  = val[11:0];
      REG_CV_OTHER_MIN:    shadow_cfg.cv_other_min_change = val[11:0];
      REG_HOLD_TICKS:      shadow_cfg.hold_ticks          = val[7:0];
      REG_CALIBRATE_MODE:  shadow_cfg.calibrate_mode      = val[0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic write_all(cfg_t c);
    reg_write(REG_KNOB_COEF,       32'(c.knob_coef));
    reg_write(REG_CV_TIME_COEF,    32'(c.cv_time_coef));
    reg_write(REG_CV_OTHER_COEF,   32'(c.cv_other_coef));
    reg_write(REG_KNOB_MIN_CHANGE, 32'(c.knob_min_change));
    reg_write(REG_CV_TIME_MIN,     32'(c.cv_time_min_change));
    reg_write(REG_CV_OTHER_MIN,    32'(c.cv_other_min_change));
    reg_write(REG_HOLD_TICKS,      32'(c.hold_ticks));
    reg_write(REG_CALIBRATE_MODE,  32'(c.calibrate_mode));
  endtask

  // kind 0: typical, 1: low end (fast filters, no deadband), 2: high end
  function automatic cfg_t pick_config(int kind);
    cfg_t c;
    c.knob_coef     = 16'($urandom_range(1) ? $urandom_range(40000, 65535) : $urandom_range(65535));
    c.cv_time_coef  = 16'($urandom_range(1) ? $urandom_range(40000, 65535) : $urandom_range(65535));
    c.cv_other_coef = 16'($urandom_range(1) ? $urandom_range(40000, 65535) : $urandom_range(65535));
    c.knob_min_change     = 12'(($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(100));
    c.cv_time_min_change  = 12'(($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(100));
    c.cv_other_min_change = 12'(($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(100));
    c.hold_ticks     = 8'($urandom_range(1, 255));
    c.calibrate_mode = 1'($urandom_range(1));
    if (kind == 1) begin
      c.knob_coef           = 16'($urandom_range(2000));
      c.cv_time_coef        = 16'd0;
      c.cv_other_coef       = 16'($urandom_range(2000));
      c.knob_min_change     = 12'd0;
      c.cv_time_min_change  = 12'd0;
      c.cv_other_min_change = 12'd0;
      c.hold_ticks          = 8'd1;
      c.calibrate_mode      = 1'b1;
    end else if (kind == 2) begin
      c.knob_coef           = 16'hFFFF;
      c.cv_other_coef       = 16'hFFFF;
      c.cv_other_min_change = SMPL_MAX;
      c.hold_ticks          = 8'd255;
      c.calibrate_mode      = 1'b0;
    end
    return c;
  endfunction

  task automatic push_item(bit src, int ch, int smp, int off, bit drain = 1'b0);
    pend_t p;
    p.it.source     = src;
    p.it.channel    = 3'(ch);
    p.it.sample     = 12'(smp);
    p.it.cal_offset = 12'(off);
    p.drain         = drain;
    stim_q.push_back(p);
  endtask

  // mostly small steps from the last value, some jumps and rails
  function automatic logic [11:0] next_sample(logic [11:0] last);
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 60) begin
      v = int'(last) + int'($urandom_range(60)) - 30;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
    end else if (r < 75) begin
      v = $urandom_range(1) ? 4095 : 0;
    end else begin
      v = int'($urandom_range(4095));
    end
    return 12'(v);
  endfunction

  task automatic push_random_item();
    bit src;
    int ch;
    int off;
    int r;
    src = 1'($urandom_range(1));
    if (!src) begin
      ch = $urandom_range(7);
      walk_knob[ch] = next_sample(walk_knob[ch]);
    end else begin
      // a few out-of-range voltage channels
      ch = ($urandom_range(99) < 12) ? int'($urandom_range(7, 6)) : int'($urandom_range(5));
      walk_cv[ch] = next_sample(walk_cv[ch]);
    end
    r = $urandom_range(99);
    if (r < 50)      off = int'($urandom_range(80)) - 40;
    else if (r < 85) off = int'($urandom_range(4095)) - 2048;
    else             off = ($urandom_range(1) ? 2047 : -2048);
    push_item(src, ch, src ? int'(walk_cv[ch]) : int'(walk_knob[ch]), off,
              $urandom_range(199) == 0);
  endtask

  // block is idle once nothing is queued, presented or outstanding
  task automatic wait_idle();
    while (stim_q.size() != 0 || in_tvalid || exp_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t c;
    int   kinds[6];
    kinds = '{0, 1, 0, 2, 0, 0};

    shadow_cfg.knob_coef           = 16'd62259;
    shadow_cfg.cv_time_coef        = 16'd64225;
    shadow_cfg.cv_other_coef       = 16'd58982;
    shadow_cfg.knob_min_change     = 12'd60;
    shadow_cfg.cv_time_min_change  = 12'd30;
    shadow_cfg.cv_other_min_change = 12'd20;
    shadow_cfg.hold_ticks          = 8'd250;
    shadow_cfg.calibrate_mode      = 1'b0;
    for (int i = 0; i < KNOB_CH; i++) begin
      knob_acc[i] = 0;
      knob_set[i] = '0;
      knob_cnt[i] = '0;
    end
    for (int i = 0; i < CV_CH; i++) begin
      cv_acc[i]     = 0;
      cv_raw_acc[i] = 0;
      cv_set[i]     = '0;
    end
    for (int i = 0; i < 8; i++) begin
      walk_knob[i] = 12'($urandom_range(4095));
      walk_cv[i]   = 12'($urandom_range(4095));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 32;
    rcv_idle_pct = 56;

    // directed, reset defaults: knob move and hold, untouched knob, voltage
    // rails in both directions, out-of-range voltage channels
    push_item(1'b0, 0, 4095, 0);
    push_item(1'b0, 0, 4095, 0);
    push_item(1'b0, 0, 4095, 0);
    push_item(1'b0, 7, 0, 0);
    push_item(1'b1, 0, 4095, 2047);
    push_item(1'b1, 5, 0, -2048);
    push_item(1'b1, 6, 123, 100);
    push_item(1'b1, 7, 4095, -1);
    push_item(1'b1, 2, 4095, 0);
    wait_idle();

    // pass-through filters, no deadband: clamp high and low, raw filter on,
    // single-tick hold
    c = shadow_cfg;
    c.knob_coef = 16'd0;  c.cv_time_coef = 16'd0;  c.cv_other_coef = 16'd0;
    c.knob_min_change = 12'd0;  c.cv_time_min_change = 12'd0;
    c.cv_other_min_change = 12'd0;
    c.hold_ticks = 8'd1;  c.calibrate_mode = 1'b1;
    write_all(c);
    push_item(1'b1, 1, 4095, 2047);
    push_item(1'b1, 1, 0, -2048);
    push_item(1'b1, 3, 2000, 5);
    push_item(1'b0, 1, 4095, 0);
    push_item(1'b0, 1, 4095, 0);
    push_item(1'b0, 1, 0, 0);
    wait_idle();

    // zero hold count swallows a detected move; calibrate off keeps the
    // last raw value; slowest voltage filters, widest deadband
    c.knob_coef = 16'd0;  c.cv_time_coef = 16'hFFFF;  c.cv_other_coef = 16'hFFFF;
    c.knob_min_change = 12'd0;  c.cv_time_min_change = SMPL_MAX;
    c.cv_other_min_change = SMPL_MAX;
    c.hold_ticks = 8'd0;  c.calibrate_mode = 1'b0;
    write_all(c);
    push_item(1'b0, 2, 4095, 0);
    push_item(1'b0, 2, 0, 0);
    push_item(1'b1, 4, 4095, 2047);
    push_item(1'b1, 3, 100, 0);
    push_item(1'b1, 0, 4095, 0);
    wait_idle();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        snd_idle_pct = 56;
        rcv_idle_pct = 32;
      end else if (ph == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_all(pick_config(kinds[ph]));
      for (int n = 0; n < PHASE_ITEMS; n++) push_random_item();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (exp_results.size() != 0)
      report_mismatch("results never seen", exp_results.size(), 0);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
